[design/wpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package wpf_pkg;

   localparam int DEF_MAX_WAYPOINTS = 64;
   localparam int DEF_FRAC_BITS     = 8;

   localparam int COORD_W = 11;
   localparam int INDEX_W = 7;
   localparam int SLOT_W  = 6;
   localparam int DRIVE_W = 13;
   localparam int CSR_W   = 11;

   localparam logic [DRIVE_W-1:0] DRIVE_LIMIT = 13'd4095;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic [1:0] STAT_STALE   = 2'd0;
   localparam logic [1:0] STAT_REACHED = 2'd1;
   localparam logic [1:0] STAT_MOVE    = 2'd2;
   localparam logic [1:0] STAT_FINISH  = 2'd3;

   // x grows to the right, y grows downward
   localparam logic [1:0] DIR_POS_X = 2'd0;
   localparam logic [1:0] DIR_NEG_X = 2'd1;
   localparam logic [1:0] DIR_NEG_Y = 2'd2;
   localparam logic [1:0] DIR_POS_Y = 2'd3;

   localparam logic [1:0] REG_ACCEPT_RADIUS = 2'd0;
   localparam logic [1:0] REG_MAX_CROSS     = 2'd1;
   localparam logic [1:0] REG_PATH_LENGTH   = 2'd2;

   localparam logic [CSR_W-1:0]   RST_ACCEPT_RADIUS = 11'd8;
   localparam logic [CSR_W-1:0]   RST_MAX_CROSS     = 11'd16;
   localparam logic [INDEX_W-1:0] RST_PATH_LENGTH   = 7'd0;

   typedef struct packed {
      logic wr_wp;
      logic set_start;
      logic load_tick;
      logic rd_prev;
      logic cap_t;
      logic diff;
      logic mul;
      logic sum;
      logic prod;
      logic div_start;
      logic foot;
      logic sq;
      logic nsum;
      logic drive;
      logic res_fin;
      logic res_stale;
      logic res_reach;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic end_path;
      logic stale;
      logic reached;
      logic seg_zero;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

[design/wpf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wpf_ram #(
   parameter int WIDTH = 22,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/wpf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wpf_div #(
   parameter int DW = 42,
   parameter int VW = 23
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [DW-1:0] quotient,
   output logic          done
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    div_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VW:0]      trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[DW-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CNT_W'(DW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = VW'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = (cnt_ff == '0);

endmodule

[design/wpf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_ctrl
// sequencer for table writes, start capture and tick processing
// ----------------------------------------------------------------------------
module wpf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_action,
   output logic               req_tready,
   input  wpf_pkg::sts_type   sts,
   output wpf_pkg::cmd_type   cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_RD_T  = 4'd2;
   localparam logic [3:0] S_RD_S  = 4'd3;
   localparam logic [3:0] S_DIFF  = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_SUM   = 4'd6;
   localparam logic [3:0] S_DEC   = 4'd7;
   localparam logic [3:0] S_PROD  = 4'd8;
   localparam logic [3:0] S_PSUM  = 4'd9;
   localparam logic [3:0] S_DIV   = 4'd10;
   localparam logic [3:0] S_FOOT  = 4'd11;
   localparam logic [3:0] S_SQ    = 4'd12;
   localparam logic [3:0] S_NSUM  = 4'd13;
   localparam logic [3:0] S_DRIVE = 4'd14;
   localparam logic [3:0] S_OUT   = 4'd15;

   logic [3:0] state_ff, state_in;
   logic       acc;

   assign req_tready = (state_ff == S_IDLE);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               unique case (req_action)
                  wpf_pkg::ACT_WRITE: cmd.wr_wp = 1'b1;
                  wpf_pkg::ACT_START: cmd.set_start = 1'b1;
                  wpf_pkg::ACT_TICK: begin
                     cmd.load_tick = 1'b1;
                     state_in      = S_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            if (sts.end_path) begin
               cmd.res_fin = 1'b1;
               state_in    = S_OUT;
            end else if (sts.stale) begin
               cmd.res_stale = 1'b1;
               state_in      = S_OUT;
            end else begin
               state_in = S_RD_T;
            end
         end
         S_RD_T: state_in = S_RD_S;
         S_RD_S: begin
            cmd.rd_prev = 1'b1;
            cmd.cap_t   = 1'b1;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (sts.reached) begin
               cmd.res_reach = 1'b1;
               state_in      = S_OUT;
            end else if (sts.seg_zero) begin
               state_in = S_FOOT;
            end else begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_PSUM;
         end
         S_PSUM: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_FOOT;
            end
         end
         S_FOOT: begin
            cmd.foot = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq   = 1'b1;
            state_in = S_NSUM;
         end
         S_NSUM: begin
            cmd.nsum = 1'b1;
            state_in = S_DRIVE;
         end
         S_DRIVE: begin
            cmd.drive = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/wpf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpf_dp
// datapath: registers, waypoint table, distance, projection and drive
// ----------------------------------------------------------------------------
module wpf_dp #(
   parameter int MAX_WAYPOINTS = wpf_pkg::DEF_MAX_WAYPOINTS,
   parameter int FRAC_BITS     = wpf_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [wpf_pkg::CSR_W-1:0]     csr_wdata,
   input  logic [wpf_pkg::SLOT_W-1:0]    in_slot,
   input  logic [wpf_pkg::COORD_W-1:0]   in_x,
   input  logic [wpf_pkg::COORD_W-1:0]   in_y,
   input  logic                          in_good,
   input  logic                          in_lost,
   input  wpf_pkg::cmd_type              cmd,
   output wpf_pkg::sts_type              sts,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [1:0]                    rsp_status,
   output logic [wpf_pkg::DRIVE_W-1:0]   rsp_drive_x,
   output logic [wpf_pkg::DRIVE_W-1:0]   rsp_drive_y,
   output logic [1:0]                    rsp_direction,
   output logic [wpf_pkg::INDEX_W-1:0]   rsp_index,
   output logic                          rsp_correcting
);

   localparam int CW  = wpf_pkg::COORD_W;
   localparam int IW  = wpf_pkg::INDEX_W;
   localparam int DW  = wpf_pkg::DRIVE_W;
   localparam int AW  = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int XW  = (AW > IW) ? AW : IW;
   localparam int PW  = 34;
   localparam int QW  = PW + FRAC_BITS;
   localparam int NW  = 15 + FRAC_BITS;
   localparam int SQW = 2 * NW;
   localparam int MW  = NW - FRAC_BITS;

   // configuration and architectural state
   logic [CW-1:0] radius_ff, mct_ff;
   logic [IW-1:0] plen_ff;
   logic [CW-1:0] start_x_ff, start_y_ff;
   logic [IW-1:0] idx_ff;
   logic          fin_ff;

   // tick sample
   logic [CW-1:0] cx_ff, cy_ff;
   logic          good_ff, lost_ff;

   // table
   logic [XW-1:0]     waddr_ext, raddr_ext;
   logic [IW-1:0]     ridx;
   logic [2*CW-1:0]   rdata;
   logic              ram_we;
   logic [CW-1:0]     tx_ff, ty_ff, sx, sy;

   // arithmetic pipeline
   logic signed [CW:0]      ex_ff, ey_ff, dx_ff, dy_ff, ux_ff, uy_ff;
   logic signed [2*CW+1:0]  pex_ff, pey_ff, pdx_ff, pdy_ff, pnx_ff, pny_ff;
   logic [2*CW:0]           e2_ff, l2_ff;
   logic signed [2*CW+1:0]  num_ff;
   logic [2*CW-1:0]         r2_ff, mct2_ff;
   logic [2*CW:0]           num_mag;
   logic [CW-1:0]           dxm, dym;
   logic [2*CW+1:0]         ppxl_ff, ppxh_ff, ppyl_ff, ppyh_ff;
   logic                    negx_ff, negy_ff;
   logic [PW-1:0]           prodx, prody;
   logic [QW-1:0]           quox, quoy;
   logic                    donex, doney;
   logic signed [NW-1:0]    qsx, qsy, nx_ff, ny_ff, exf, eyf, ux_ext, uy_ext;
   logic signed [2*NW-1:0]  sqx_ff, sqy_ff;
   logic [SQW-1:0]          nn, lim2;
   logic                    corr_ff;
   logic signed [NW-1:0]    selx, sely;
   logic [NW-1:0]           ax, ay, amag;
   logic [MW-1:0]           pmag;
   logic [DW-1:0]           pdrv;

   // result and output registers
   logic [1:0]    res_status_ff, res_dir_ff;
   logic [DW-1:0] res_dx_ff, res_dy_ff;
   logic          res_corr_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff, rsp_dir_ff;
   logic [DW-1:0] rsp_dx_ff, rsp_dy_ff;
   logic [IW-1:0] rsp_idx_ff;
   logic          rsp_corr_ff;

   // --- table -------------------------------------------------------------
   assign ram_we    = cmd.wr_wp && (32'(in_slot) < MAX_WAYPOINTS);
   assign waddr_ext = XW'(in_slot);
   assign ridx      = cmd.rd_prev ? IW'(idx_ff - 1'b1) : idx_ff;
   assign raddr_ext = XW'(ridx);

   wpf_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_WAYPOINTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_ext[AW-1:0]),
      .wdata ({in_y, in_x}),
      .raddr (raddr_ext[AW-1:0]),
      .rdata (rdata)
   );

   assign sx = (idx_ff != '0) ? rdata[CW-1:0]    : start_x_ff;
   assign sy = (idx_ff != '0) ? rdata[2*CW-1:CW] : start_y_ff;

   // --- status --------------------------------------------------------------
   assign sts.end_path = fin_ff || lost_ff || (idx_ff >= plen_ff)
                         || (32'(idx_ff) >= MAX_WAYPOINTS);
   assign sts.stale    = !good_ff;
   assign sts.reached  = (e2_ff < {1'b0, r2_ff});
   assign sts.seg_zero = (l2_ff == '0);
   assign sts.div_done = donex && doney;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // --- projection ----------------------------------------------------------
   assign num_mag = num_ff[2*CW+1] ? (2*CW+1)'(-num_ff) : num_ff[2*CW:0];
   assign dxm     = dx_ff[CW] ? CW'(-dx_ff) : dx_ff[CW-1:0];
   assign dym     = dy_ff[CW] ? CW'(-dy_ff) : dy_ff[CW-1:0];
   assign prodx   = PW'(ppxl_ff) + (PW'(ppxh_ff) << 12);
   assign prody   = PW'(ppyl_ff) + (PW'(ppyh_ff) << 12);

   wpf_div #(.DW(QW), .VW(2 * CW + 1)) u_divx (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (QW'(prodx) << FRAC_BITS),
      .divisor  (l2_ff),
      .quotient (quox),
      .done     (donex)
   );

   wpf_div #(.DW(QW), .VW(2 * CW + 1)) u_divy (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (QW'(prody) << FRAC_BITS),
      .divisor  (l2_ff),
      .quotient (quoy),
      .done     (doney)
   );

   assign qsx    = negx_ff ? -$signed({1'b0, quox[NW-2:0]}) : $signed({1'b0, quox[NW-2:0]});
   assign qsy    = negy_ff ? -$signed({1'b0, quoy[NW-2:0]}) : $signed({1'b0, quoy[NW-2:0]});
   assign ux_ext = NW'(ux_ff) <<< FRAC_BITS;
   assign uy_ext = NW'(uy_ff) <<< FRAC_BITS;
   assign exf    = NW'(ex_ff) <<< FRAC_BITS;
   assign eyf    = NW'(ey_ff) <<< FRAC_BITS;

   assign nn   = SQW'(unsigned'(sqx_ff)) + SQW'(unsigned'(sqy_ff));
   assign lim2 = SQW'(mct2_ff) << (2 * FRAC_BITS);

   // --- drive ---------------------------------------------------------------
   assign selx = corr_ff ? nx_ff : exf;
   assign sely = corr_ff ? ny_ff : eyf;
   assign ax   = selx[NW-1] ? NW'(-selx) : NW'(selx);
   assign ay   = sely[NW-1] ? NW'(-sely) : NW'(sely);
   assign amag = (ax > ay) ? ax : ay;
   assign pmag = amag[NW-1:FRAC_BITS];
   assign pdrv = (pmag > MW'(wpf_pkg::DRIVE_LIMIT)) ? wpf_pkg::DRIVE_LIMIT : DW'(pmag);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= wpf_pkg::RST_ACCEPT_RADIUS;
         mct_ff       <= wpf_pkg::RST_MAX_CROSS;
         plen_ff      <= wpf_pkg::RST_PATH_LENGTH;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         idx_ff       <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               wpf_pkg::REG_ACCEPT_RADIUS: radius_ff <= csr_wdata;
               wpf_pkg::REG_MAX_CROSS:     mct_ff    <= csr_wdata;
               wpf_pkg::REG_PATH_LENGTH:   plen_ff   <= csr_wdata[IW-1:0];
               default: ;
            endcase
         end
         if (cmd.set_start) begin
            start_x_ff <= in_x;
            start_y_ff <= in_y;
         end
         if (cmd.res_reach) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.res_fin) begin
            fin_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tick) begin
         cx_ff   <= in_x;
         cy_ff   <= in_y;
         good_ff <= in_good;
         lost_ff <= in_lost;
      end
      if (cmd.cap_t) begin
         tx_ff <= rdata[CW-1:0];
         ty_ff <= rdata[2*CW-1:CW];
      end
      if (cmd.diff) begin
         ex_ff <= $signed({1'b0, tx_ff}) - $signed({1'b0, cx_ff});
         ey_ff <= $signed({1'b0, ty_ff}) - $signed({1'b0, cy_ff});
         dx_ff <= $signed({1'b0, tx_ff}) - $signed({1'b0, sx});
         dy_ff <= $signed({1'b0, ty_ff}) - $signed({1'b0, sy});
         ux_ff <= $signed({1'b0, cx_ff}) - $signed({1'b0, sx});
         uy_ff <= $signed({1'b0, cy_ff}) - $signed({1'b0, sy});
      end
      if (cmd.mul) begin
         pex_ff  <= (2*CW+2)'(ex_ff * ex_ff);
         pey_ff  <= (2*CW+2)'(ey_ff * ey_ff);
         pdx_ff  <= (2*CW+2)'(dx_ff * dx_ff);
         pdy_ff  <= (2*CW+2)'(dy_ff * dy_ff);
         pnx_ff  <= (2*CW+2)'(ux_ff * dx_ff);
         pny_ff  <= (2*CW+2)'(uy_ff * dy_ff);
         r2_ff   <= (2*CW)'(radius_ff * radius_ff);
         mct2_ff <= (2*CW)'(mct_ff * mct_ff);
      end
      if (cmd.sum) begin
         e2_ff  <= (2*CW+1)'(pex_ff + pey_ff);
         l2_ff  <= (2*CW+1)'(pdx_ff + pdy_ff);
         num_ff <= pnx_ff + pny_ff;
      end
      if (cmd.prod) begin
         ppxl_ff <= (2*CW+2)'(dxm * num_mag[11:0]);
         ppxh_ff <= (2*CW+2)'(dxm * num_mag[2*CW:12]);
         ppyl_ff <= (2*CW+2)'(dym * num_mag[11:0]);
         ppyh_ff <= (2*CW+2)'(dym * num_mag[2*CW:12]);
         negx_ff <= dx_ff[CW] ^ num_ff[2*CW+1];
         negy_ff <= dy_ff[CW] ^ num_ff[2*CW+1];
      end
      if (cmd.foot) begin
         if (l2_ff == '0) begin
            nx_ff <= exf;
            ny_ff <= eyf;
         end else begin
            nx_ff <= qsx - ux_ext;
            ny_ff <= qsy - uy_ext;
         end
      end
      if (cmd.sq) begin
         sqx_ff <= nx_ff * nx_ff;
         sqy_ff <= ny_ff * ny_ff;
      end
      if (cmd.nsum) begin
         corr_ff <= (nn > lim2);
      end
      if (cmd.res_fin || cmd.res_stale || cmd.res_reach) begin
         res_status_ff <= cmd.res_fin ? wpf_pkg::STAT_FINISH :
                          (cmd.res_reach ? wpf_pkg::STAT_REACHED : wpf_pkg::STAT_STALE);
         res_dx_ff     <= '0;
         res_dy_ff     <= '0;
         res_dir_ff    <= wpf_pkg::DIR_POS_X;
         res_corr_ff   <= 1'b0;
      end
      if (cmd.drive) begin
         res_status_ff <= wpf_pkg::STAT_MOVE;
         res_corr_ff   <= corr_ff;
         if (ax > ay) begin
            res_dy_ff <= '0;
            if (selx > 0) begin
               res_dx_ff  <= pdrv;
               res_dir_ff <= wpf_pkg::DIR_POS_X;
            end else begin
               res_dx_ff  <= DW'(-pdrv);
               res_dir_ff <= wpf_pkg::DIR_NEG_X;
            end
         end else begin
            res_dx_ff <= '0;
            if (sely > 0) begin
               res_dy_ff  <= pdrv;
               res_dir_ff <= wpf_pkg::DIR_POS_Y;
            end else begin
               res_dy_ff  <= DW'(-pdrv);
               res_dir_ff <= wpf_pkg::DIR_NEG_Y;
            end
         end
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_dx_ff     <= res_dx_ff;
         rsp_dy_ff     <= res_dy_ff;
         rsp_dir_ff    <= res_dir_ff;
         rsp_idx_ff    <= idx_ff;
         rsp_corr_ff   <= res_corr_ff;
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_drive_x    = rsp_dx_ff;
   assign rsp_drive_y    = rsp_dy_ff;
   assign rsp_direction  = rsp_dir_ff;
   assign rsp_index      = rsp_idx_ff;
   assign rsp_correcting = rsp_corr_ff;

endmodule

[design/waypoint_path_follower_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_path_follower_unit
// steers a tracked object along a stored waypoint list
// ----------------------------------------------------------------------------
// write and start transactions complete when accepted; ticks are processed one at a time
// a finish or stale tick is resolved at the check step, a reached waypoint after the
// distance steps; moves on a non-zero segment use the serial divider (one bit/cycle)
// the result sits in an output register while the next transaction is taken
// synchronous reset restores register defaults, index, finish flag and start
// point; waypoint table contents are undefined until written
module waypoint_path_follower_unit #(
   parameter int MAX_WAYPOINTS = wpf_pkg::DEF_MAX_WAYPOINTS,
   parameter int FRAC_BITS     = wpf_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // slot, pos_x, pos_y, sample_good, driver_lost
   input  logic [1:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // drive_x, drive_y, direction, waypoint_index, correcting
   output logic [1:0]  rsp_tuser   // status
);

   wpf_pkg::cmd_type cmd;
   wpf_pkg::sts_type sts;

   logic [12:0] drive_x, drive_y;
   logic [1:0]  direction;
   logic [6:0]  waypoint_index;
   logic        correcting;

   wpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wpf_dp #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS),
      .FRAC_BITS     (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .in_slot        (req_tdata[5:0]),
      .in_x           (req_tdata[16:6]),
      .in_y           (req_tdata[27:17]),
      .in_good        (req_tdata[28]),
      .in_lost        (req_tdata[29]),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_status     (rsp_tuser),
      .rsp_drive_x    (drive_x),
      .rsp_drive_y    (drive_y),
      .rsp_direction  (direction),
      .rsp_index      (waypoint_index),
      .rsp_correcting (correcting)
   );

   assign rsp_tdata = {4'b0, correcting, waypoint_index, direction, drive_y, drive_x};

endmodule
